### rtl/palette_upscaler_3to5_rows_assert.svh
// assertion macros for the palette upscaler rtl
// no dependencies; included by the top level only
`ifndef PALETTE_UPSCALER_3TO5_ROWS_ASSERT_SVH
`define PALETTE_UPSCALER_3TO5_ROWS_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PU35_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// antecedent implies consequent in the next cycle
`define PU35_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define PU35_ASSERT_NOW(label, clk, rst, ante, cons)
`define PU35_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/pu35_pkg.sv
// shared constants, types and color functions of the palette upscaler
// no dependencies
package pu35_pkg;

   localparam int SRC_WIDTH  = 160;
   localparam int SRC_HEIGHT = 144;
   localparam int COL_W      = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
   localparam int ROW_W      = $clog2(SRC_HEIGHT);
   localparam int PAL_DEPTH  = 256;
   localparam int PAL_AW     = 8;
   localparam int COLOR_W    = 16;
   localparam int POS_W      = 8;

   localparam logic [POS_W-1:0] GROUP_STEP = 8'd5;
   localparam logic [31:0] CH_MASK = 32'h07e0f81f;
   localparam logic [31:0] CH_LSB  = 32'h00200801;

   typedef enum logic [1:0] {
      PH_ROW0  = 2'd0,
      PH_BLEND = 2'd1,
      PH_ROW2  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      phase_type        phase;
      logic [POS_W-1:0] group;
   } pos_type;

   function automatic logic [COLOR_W-1:0] pack565(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic logic [31:0] spread565(input logic [COLOR_W-1:0] c);
      return ({16'h0000, c} | {c, 16'h0000}) & CH_MASK;
   endfunction

   // per-channel average, round half to even
   function automatic logic [COLOR_W-1:0] blend565(input logic [COLOR_W-1:0] c0,
                                                   input logic [COLOR_W-1:0] c1);
      logic [31:0] s;
      logic [31:0] h;
      s = spread565(c0) + spread565(c1);
      s = s + (CH_LSB & (s >> 1));
      h = (s >> 1) & CH_MASK;
      return h[15:0] | h[31:16];
   endfunction

endpackage

### rtl/pu35_palette.sv
// 256 x 16 palette ram with a registered read and a clearing sweep
// after reset; uses pu35_pkg
module pu35_palette (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [pu35_pkg::PAL_AW-1:0]    wr_addr,
   input  logic [pu35_pkg::COLOR_W-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [pu35_pkg::PAL_AW-1:0]    rd_addr,
   output logic [pu35_pkg::COLOR_W-1:0]   rd_data,
   output logic                           clearing
);
   import pu35_pkg::*;

   logic [COLOR_W-1:0] mem [PAL_DEPTH];
   logic               clr_busy_ff;
   logic [PAL_AW-1:0]  clr_addr_ff;
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == PAL_AW'(PAL_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;
endmodule

### rtl/pu35_line_buf.sv
// line buffer holding the colors of row 0 of the current row group
// one write and one registered read port; uses pu35_pkg
module pu35_line_buf (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [pu35_pkg::COL_W-1:0]     wr_addr,
   input  logic [pu35_pkg::COLOR_W-1:0]   wr_data,
   input  logic                           rd_en,
   input  logic [pu35_pkg::COL_W-1:0]     rd_addr,
   output logic [pu35_pkg::COLOR_W-1:0]   rd_data
);
   import pu35_pkg::*;

   logic [COLOR_W-1:0] mem [SRC_WIDTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/pu35_pos.sv
// raster position tracker: column, row phase, output row base, source row
// uses pu35_pkg
module pu35_pos (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               restart,
   output pu35_pkg::pos_type  pos
);
   import pu35_pkg::*;

   pos_type          pos_ff;
   pos_type          pos_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   pos_type          base;
   logic [ROW_W-1:0] base_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      base     = restart ? pos_type'('0) : pos_ff;
      base_row = restart ? '0 : row_ff;
      pos_in   = base;
      row_in   = base_row;
      if (base.col == COL_W'(SRC_WIDTH - 1)) begin
         pos_in.col = '0;
         if (base_row == ROW_W'(SRC_HEIGHT - 1)) begin
            row_in       = '0;
            pos_in.phase = PH_ROW0;
            pos_in.group = '0;
         end else begin
            row_in = base_row + 1'b1;
            unique case (base.phase)
               PH_ROW0:  pos_in.phase = PH_BLEND;
               PH_BLEND: pos_in.phase = PH_ROW2;
               default: begin
                  pos_in.phase = PH_ROW0;
                  pos_in.group = base.group + GROUP_STEP;
               end
            endcase
         end
      end else begin
         pos_in.col = base.col + 1'b1;
      end
   end

   assign pos = base;
endmodule

### rtl/palette_upscaler_3to5_rows.sv
// top level of the palette lookup scaler (3 rows to 5, columns doubled)
// uses pu35_pkg, pu35_palette, pu35_line_buf, pu35_pos and the assert header
//
// channel  | ports  | moves
// ---------+--------+----------------------------------------------------
// request  | req_*  | palette write or source pixel index, valid/ready
// response | rsp_*  | output row, column pair, rgb565 color, last flag
//
// palette writes give no response, row-0 pixels give one, blend-row and row-2
// pixels two; the single output register emits one response a cycle while
// rsp_ready holds; a pixel reads palette and line buffer at acceptance, and
// its responses go from the pixel stage into the output register
// after reset the palette is swept to zero, all 256 entries, req_ready stays low
// a stalled response holds in the output register; besides the sweep, req_ready
// drops whenever the pixel stage holds a pixel not handing on its last response
`include "palette_upscaler_3to5_rows_assert.svh"
module palette_upscaler_3to5_rows (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic        req_frame_start,
   input  logic [7:0]  req_palette_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_pixel_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_row,
   output logic [7:0]  rsp_out_pair,
   output logic [15:0] rsp_color,
   output logic        rsp_last
);
   import pu35_pkg::*;

   // request side
   logic               req_fire;
   logic               pix_fire;
   logic               pal_wr_fire;
   logic               pal_clearing;
   logic [COLOR_W-1:0] pal_q;
   logic [COLOR_W-1:0] lb_q;
   pos_type            pos;

   // pixel stage: one pixel waiting for its results to leave
   logic               s1_valid_ff;
   logic [COL_W-1:0]   s1_col_ff;
   phase_type          s1_phase_ff;
   logic [POS_W-1:0]   s1_group_ff;
   logic               s1_sub_ff;
   logic               s1_fwd_ff;
   logic [COLOR_W-1:0] s1_fwd_color_ff;
   logic               fwd_in;

   logic               s1_last;
   logic               s1_fire;
   logic               s1_done;
   logic               out_free;
   logic [COLOR_W-1:0] top_color;
   logic [POS_W-1:0]   res_row;
   logic [COLOR_W-1:0] res_color;
   logic               res_last;

   // output register
   logic               out_valid_ff;
   logic [7:0]         out_row_ff;
   logic [7:0]         out_pair_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_last_ff;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign s1_last     = (s1_phase_ff == PH_ROW0) || s1_sub_ff;
   assign s1_fire     = s1_valid_ff && out_free;
   assign s1_done     = s1_fire && s1_last;
   assign req_ready   = !pal_clearing && (!s1_valid_ff || s1_done);
   assign req_fire    = req_valid && req_ready;
   assign pix_fire    = req_fire && req_operation;
   assign pal_wr_fire = req_fire && !req_operation;

   pu35_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pal_wr_fire),
      .wr_addr  (req_palette_index),
      .wr_data  (pack565(req_red, req_green, req_blue)),
      .rd_en    (pix_fire),
      .rd_addr  (req_pixel_index),
      .rd_data  (pal_q),
      .clearing (pal_clearing)
   );

   // row 0 colors are written while the pixel sits in the pixel stage
   pu35_line_buf u_line_buf (
      .clock   (clock),
      .wr_en   (s1_valid_ff && (s1_phase_ff == PH_ROW0)),
      .wr_addr (s1_col_ff),
      .wr_data (pal_q),
      .rd_en   (pix_fire),
      .rd_addr (pos.col),
      .rd_data (lb_q)
   );

   pu35_pos u_pos (
      .clock   (clock),
      .reset   (reset),
      .advance (pix_fire),
      .restart (req_frame_start),
      .pos     (pos)
   );

   // a row-0 write to the same column may land on the edge the next pixel
   // reads it (one-column frames), so carry its color across
   assign fwd_in = s1_valid_ff && (s1_phase_ff == PH_ROW0) && (s1_col_ff == pos.col);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_sub_ff   <= 1'b0;
      end else if (pix_fire) begin
         s1_valid_ff <= 1'b1;
         s1_sub_ff   <= 1'b0;
      end else if (s1_done) begin
         s1_valid_ff <= 1'b0;
         s1_sub_ff   <= 1'b0;
      end else if (s1_fire) begin
         s1_sub_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         s1_col_ff       <= pos.col;
         s1_phase_ff     <= pos.phase;
         s1_group_ff     <= pos.group;
         s1_fwd_ff       <= fwd_in;
         s1_fwd_color_ff <= pal_q;
      end
   end

   assign top_color = s1_fwd_ff ? s1_fwd_color_ff : lb_q;

   // pick the response for the current sub-step of the pixel
   always_comb begin
      res_row   = s1_group_ff;
      res_color = pal_q;
      res_last  = 1'b1;
      unique case (s1_phase_ff)
         PH_ROW0: begin
            res_row = s1_group_ff;
         end
         PH_BLEND: begin
            if (!s1_sub_ff) begin
               res_row   = s1_group_ff + 8'd1;
               res_color = blend565(top_color, pal_q);
               res_last  = 1'b0;
            end else begin
               res_row = s1_group_ff + 8'd2;
            end
         end
         default: begin
            res_row  = s1_sub_ff ? (s1_group_ff + 8'd4) : (s1_group_ff + 8'd3);
            res_last = s1_sub_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_row_ff   <= res_row;
         out_pair_ff  <= 8'(s1_col_ff);
         out_color_ff <= res_color;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_row  = out_row_ff;
   assign rsp_out_pair = out_pair_ff;
   assign rsp_color    = out_color_ff;
   assign rsp_last     = out_last_ff;

   // no transaction is taken while the palette sweep runs
   `PU35_ASSERT_NOW(a_no_accept_in_clear, clock, reset, req_fire, !pal_clearing)
   // a new pixel never overwrites one with responses still pending
   `PU35_ASSERT_NOW(a_stage_free, clock, reset, pix_fire, !s1_valid_ff || s1_done)
   // first of two responses is followed by the second from the same pixel
   `PU35_ASSERT_NEXT(a_second_resp, clock, reset, s1_fire && !s1_last, s1_valid_ff && s1_sub_ff)
   // a response is only loaded from a valid pixel stage
   `PU35_ASSERT_NEXT(a_out_source, clock, reset, out_free && !s1_valid_ff, !out_valid_ff)

endmodule

### test/pu35_tb_pkg.sv
`timescale 1ns / 100ps
// request operation codes shared by the upscaler testbench top and its checker
// no dependencies
package pu35_tb_pkg;

   typedef enum logic {
      OP_PALETTE_WRITE = 1'b0,
      OP_PIXEL         = 1'b1
   } req_op_type;

endpackage

### test/pu35_checker.sv
`timescale 1ns / 100ps
// response checker of the palette upscaler: predicts scaled pixels, compares in order
// uses pu35_pkg (geometry, row phases) and pu35_tb_pkg (operation codes)
module pu35_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_operation,
   input  logic        req_frame_start,
   input  logic [7:0]  req_palette_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_pixel_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_row,
   input  logic [7:0]  rsp_out_pair,
   input  logic [15:0] rsp_color,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count
);
   import pu35_pkg::*;
   import pu35_tb_pkg::*;

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [7:0]  row;
      logic [7:0]  pair;
      logic [15:0] color;
      logic        last;
   } scaled_pixel_t;

   scaled_pixel_t scaled_pixels_q[$];

   logic [15:0] palette_mem [256];
   logic [15:0] top_row_colors [SRC_WIDTH];
   int          col_count;
   int          src_row;
   phase_type   row_phase;
   logic [7:0]  group_row;
   int          errors;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      errors        = 0;
   end

   // printing stops after a while, counting does not
   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      if (errors < PRINT_LIMIT)
         $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
   endtask

   // per-channel rgb565 average, ties go to the even value
   function automatic logic [15:0] average565(input logic [15:0] a, input logic [15:0] b);
      logic [5:0] rs;
      logic [6:0] gs;
      logic [5:0] bs;
      rs = {1'b0, a[15:11]} + {1'b0, b[15:11]};
      gs = {1'b0, a[10:5]} + {1'b0, b[10:5]};
      bs = {1'b0, a[4:0]} + {1'b0, b[4:0]};
      rs = rs + rs[1];
      gs = gs + gs[1];
      bs = bs + bs[1];
      return {rs[5:1], gs[6:1], bs[5:1]};
   endfunction

   task automatic queue_scaled(input logic [7:0] row, input logic [15:0] color,
                               input logic last);
      scaled_pixel_t px;
      px.row   = row;
      px.pair  = col_count[7:0];
      px.color = color;
      px.last  = last;
      scaled_pixels_q.push_back(px);
   endtask

   task automatic upscale_request();
      logic [15:0] c;
      if (req_operation == OP_PALETTE_WRITE) begin
         palette_mem[req_palette_index] = {req_red[7:3], req_green[7:2], req_blue[7:3]};
         return;
      end
      if (req_frame_start) begin
         col_count = 0;
         src_row   = 0;
         row_phase = PH_ROW0;
         group_row = 8'd0;
      end
      c = palette_mem[req_pixel_index];
      case (row_phase)
         PH_ROW0: begin
            top_row_colors[col_count] = c;
            queue_scaled(group_row, c, 1'b1);
         end
         PH_BLEND: begin
            queue_scaled(group_row + 8'd1, average565(top_row_colors[col_count], c), 1'b0);
            queue_scaled(group_row + 8'd2, c, 1'b1);
         end
         default: begin
            queue_scaled(group_row + 8'd3, c, 1'b0);
            queue_scaled(group_row + 8'd4, c, 1'b1);
         end
      endcase
      col_count++;
      if (col_count >= SRC_WIDTH) begin
         col_count = 0;
         src_row++;
         if (src_row >= SRC_HEIGHT) begin
            src_row   = 0;
            row_phase = PH_ROW0;
            group_row = 8'd0;
         end else if (row_phase == PH_ROW2) begin
            row_phase = PH_ROW0;
            group_row = group_row + 8'd5;
         end else begin
            row_phase = (row_phase == PH_ROW0) ? PH_BLEND : PH_ROW2;
         end
      end
   endtask

   task automatic check_response();
      scaled_pixel_t want;
      if (scaled_pixels_q.size() == 0) begin
         report("response with nothing expected, row/pair", {rsp_out_row, rsp_out_pair}, 16'h0);
         return;
      end
      want = scaled_pixels_q.pop_front();
      if (rsp_out_row !== want.row)
         report("out_row mismatch", {8'h0, rsp_out_row}, {8'h0, want.row});
      if (rsp_out_pair !== want.pair)
         report("out_pair mismatch", {8'h0, rsp_out_pair}, {8'h0, want.pair});
      if (rsp_color !== want.color)
         report("color mismatch", rsp_color, want.color);
      if (rsp_last !== want.last)
         report("last mismatch", {15'h0, rsp_last}, {15'h0, want.last});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (palette_mem[i])
            palette_mem[i] = 16'h0000;
         col_count = 0;
         src_row   = 0;
         row_phase = PH_ROW0;
         group_row = 8'd0;
         scaled_pixels_q.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_response();
         if (req_valid && req_ready)
            upscale_request();
      end
      pending_count <= scaled_pixels_q.size();
      fail_count    <= errors;
   end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// testbench top of palette_upscaler_3to5_rows: stimulus, handshake idling, verdict
// uses pu35_pkg, pu35_tb_pkg, pu35_checker and the rtl of the block
module tb_top;
   import pu35_pkg::*;
   import pu35_tb_pkg::*;

   // the block clears all 256 palette entries after reset with req_ready low,
   // so the quiet-cycle limit sits well above the length of that sweep
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1600;
   // a pixel's first result passes the pixel stage and the output register before
   // it can be taken; a short tail catches strays
   localparam int TAIL_CYCLES  = 20;

   logic        clock;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_operation     = 1'b0;
   logic        req_frame_start   = 1'b0;
   logic [7:0]  req_palette_index = 8'd0;
   logic [7:0]  req_red           = 8'd0;
   logic [7:0]  req_green         = 8'd0;
   logic [7:0]  req_blue          = 8'd0;
   logic [7:0]  req_pixel_index   = 8'd0;
   logic        rsp_ready         = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_out_row;
   logic [7:0]  rsp_out_pair;
   logic [15:0] rsp_color;
   logic        rsp_last;

   int          fail_count;
   int          pending_count;
   logic        idle_on     = 1'b1;
   int          items_sent  = 0;
   int          quiet_cycles = 0;

   palette_upscaler_3to5_rows dut (.*);

   // watches both channels, predicts and compares on its own
   pu35_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side: stalls about 27 percent of the time unless idling is off
   always @(posedge clock)
      rsp_ready <= !idle_on || ($urandom_range(0, 99) >= 27);

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // one request transaction; a random gap may come first, valid then holds until taken
   task automatic send_request(input req_op_type op, input logic fs, input logic [7:0] pidx,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [7:0] px);
      // a long stretch with no gaps on either side
      idle_on <= !(items_sent >= 600 && items_sent < 1000);
      while (idle_on && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_frame_start   <= fs;
      req_palette_index <= pidx;
      req_red           <= r;
      req_green         <= g;
      req_blue          <= b;
      req_pixel_index   <= px;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // unused fields carry random junk so the block has to ignore them
   task automatic write_palette(input logic fs, input logic [7:0] idx,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
      send_request(OP_PALETTE_WRITE, fs, idx, r, g, b, $urandom_range(0, 255));
   endtask

   task automatic send_pixel(input logic fs, input logic [7:0] px);
      send_request(OP_PIXEL, fs, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), px);
   endtask

   task automatic random_palette_write();
      write_palette($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // sender holds off until every predicted response has been taken
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   initial begin
      int run_len;
      int burst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // palette writes: full scale, lowest surviving bits, pure channels,
      // bits that the packing drops; frame_start on a write must be ignored
      write_palette(1'b1, 8'd0, 8'hff, 8'hff, 8'hff);
      write_palette(1'b0, 8'd255, 8'h08, 8'h04, 8'h08);
      write_palette(1'b0, 8'd1, 8'hff, 8'h00, 8'h00);
      write_palette(1'b0, 8'd2, 8'h00, 8'hff, 8'h00);
      write_palette(1'b0, 8'd3, 8'h00, 8'h00, 8'hff);
      write_palette(1'b0, 8'd4, 8'h07, 8'h03, 8'h07);
      // row 0 pixels, including an entry still at its cleared value
      send_pixel(1'b1, 8'd0);
      send_pixel(1'b0, 8'd255);
      send_pixel(1'b0, 8'd1);
      send_pixel(1'b0, 8'd2);
      send_pixel(1'b0, 8'd3);
      send_pixel(1'b0, 8'd4);
      send_pixel(1'b0, 8'd200);
      // a palette change in mid row shows up on the very next lookup
      write_palette(1'b0, 8'd0, 8'h10, 8'h20, 8'h30);
      send_pixel(1'b0, 8'd0);
      // restart in mid row, then a write with frame_start keeps the position
      send_pixel(1'b1, 8'd255);
      write_palette(1'b1, 8'd5, 8'h80, 8'h40, 8'hc0);
      send_pixel(1'b0, 8'd5);
      drain_responses();

      // --- random part ---
      // mostly runs that start a frame with random colors, the long ones going
      // through row 0, blend and row 2 phases; the rest is raw noise on every field
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(320, 700)
                                                  : $urandom_range(1, 200);
            if (run_len > RANDOM_ITEMS - items_sent)
               run_len = RANDOM_ITEMS - items_sent;
            send_pixel(1'b1, $urandom_range(0, 255));
            repeat (run_len - 1) begin
               if ($urandom_range(0, 9) == 0)
                  random_palette_write();
               send_pixel(1'b0, $urandom_range(0, 255));
            end
         end else begin
            burst = $urandom_range(1, 30);
            repeat (burst)
               send_request(req_op_type'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
         end
         if ($urandom_range(0, 7) == 0)
            drain_responses();
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/pu35_pkg.sv
rtl/pu35_palette.sv
rtl/pu35_line_buf.sv
rtl/pu35_pos.sv
rtl/palette_upscaler_3to5_rows.sv
test/pu35_tb_pkg.sv
test/pu35_checker.sv
test/tb_top.sv
